// ===== rtl/mbsp_pkg.sv =====
// Package with the shared types of the MIDI byte stream parser.
`timescale 1ns / 1ps

package mbsp_pkg;

  // Parse phase codes; the codes in between are never entered.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ONE    = 3'd2,
    PH_FIRST  = 3'd3,
    PH_SECOND = 3'd4
  } phase_e;

  // Status byte codes with a meaning of their own.
  localparam logic [7:0] ST_SPP      = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONT     = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;
  localparam logic [7:0] ST_OVERRUN  = 8'hFE;
  localparam logic [7:0] ST_RESET    = 8'hFF;

  // Upper nibbles of the channel messages with one data byte, and of the system messages.
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_CHAN_AT  = 4'hD;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

  // Parser state carried between bytes.
  typedef struct packed {
    phase_e     phase;
    logic [7:0] running_status;
    logic [6:0] first_data;
  } parse_state_t;

  // One emitted message.
  typedef struct packed {
    logic       valid;
    logic [1:0] length;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
  } midi_msg_t;

endpackage

// ===== rtl/mbsp_decode.sv =====
// Combinational decode of one received byte against the parser state.
`timescale 1ns / 1ps

module mbsp_decode
  import mbsp_pkg::*;
(
  input  logic [7:0]   rx_byte_i,
  input  parse_state_t state_i,
  output parse_state_t state_o,
  output midi_msg_t    msg_o
);

  always_comb begin
    state_o = state_i;
    msg_o   = '0;
    if (rx_byte_i[7]) begin
      // Status byte.
      if (rx_byte_i[7:4] == HI_SYSTEM) begin
        unique case (rx_byte_i)
          ST_RESET, ST_OVERRUN: begin
            state_o.phase          = PH_IDLE;
            state_o.running_status = '0;
            msg_o.valid            = 1'b1;
            msg_o.length           = 2'd1;
            msg_o.status           = rx_byte_i;
          end
          ST_CLOCK, ST_START, ST_CONT, ST_STOP, ST_TUNE: begin
            // Real-time and tune request pass through untouched.
            msg_o.valid  = 1'b1;
            msg_o.length = 2'd1;
            msg_o.status = rx_byte_i;
          end
          ST_SPP: begin
            state_o.phase          = PH_FIRST;
            state_o.running_status = rx_byte_i;
          end
          ST_SONG_SEL: begin
            state_o.phase          = PH_ONE;
            state_o.running_status = rx_byte_i;
          end
          default: begin
            state_o.phase          = PH_IDLE;
            state_o.running_status = '0;
          end
        endcase
      end else begin
        // Channel message: program change and channel aftertouch take one data byte.
        if (rx_byte_i[7:4] == HI_PROGRAM || rx_byte_i[7:4] == HI_CHAN_AT) begin
          state_o.phase = PH_ONE;
        end else begin
          state_o.phase = PH_FIRST;
        end
        state_o.running_status = rx_byte_i;
      end
    end else begin
      // Data byte, handled by phase.
      unique case (state_i.phase)
        PH_FIRST: begin
          state_o.first_data = rx_byte_i[6:0];
          state_o.phase      = PH_SECOND;
        end
        PH_ONE: begin
          msg_o.valid  = 1'b1;
          msg_o.length = 2'd2;
          msg_o.status = state_i.running_status;
          msg_o.data1  = rx_byte_i[6:0];
        end
        PH_SECOND: begin
          state_o.phase = PH_FIRST;
          msg_o.valid   = 1'b1;
          msg_o.length  = 2'd3;
          msg_o.status  = state_i.running_status;
          msg_o.data1   = state_i.first_data;
          msg_o.data2   = rx_byte_i[6:0];
        end
        default: begin
          // No status yet: the byte is dropped.
        end
      endcase
    end
  end

endmodule

// ===== rtl/midi_byte_stream_parser.sv =====
// Top level of the MIDI byte stream parser with running status.
//
//   Channel   Direction  Width  Contents
//   s_axis    in         8      rx_byte
//   m_axis    out        24     msg_length, msg_status, msg_data1, msg_data2
//
// A byte is registered on acceptance, decoded in the next cycle and its message,
// if any, lands in the output register once that register is free or draining.
// One byte is taken every cycle while the output register is free or draining.
// Reset clears the parse state, running status and both valid flags.
// A stall on the master side holds the output and backs up into s_axis_tready.
`timescale 1ns / 1ps

module midi_byte_stream_parser
  import mbsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [1:0] msg_length, [9:2] msg_status,
                                      // [16:10] msg_data1, [23:17] msg_data2
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  parse_state_t state_q, state_d;
  midi_msg_t    msg_d, msg_q;
  logic         advance;

  // The input stage moves on whenever the output register is free or draining.
  assign advance       = !msg_q.valid || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  mbsp_decode u_decode (
    .rx_byte_i (in_byte_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .msg_o     (msg_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Parse state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, running_status: 8'h00, first_data: 7'h00};
      msg_q   <= '0;
    end else if (advance) begin
      msg_q.valid <= in_valid_q && msg_d.valid;
      if (in_valid_q) begin
        state_q <= state_d;
        if (msg_d.valid) begin
          msg_q.length <= msg_d.length;
          msg_q.status <= msg_d.status;
          msg_q.data1  <= msg_d.data1;
          msg_q.data2  <= msg_d.data2;
        end
      end
    end
  end

  assign m_axis_tvalid = msg_q.valid;
  assign m_axis_tdata  = {msg_q.data2, msg_q.data1, msg_q.status, msg_q.length};

  // Short messages carry zero in their unused data bytes.
  a_len1_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (msg_q.valid && msg_q.length == 2'd1) |-> (msg_q.data1 == 7'd0 && msg_q.data2 == 7'd0))
    else $error("one-byte message with nonzero data");

  a_len2_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (msg_q.valid && msg_q.length == 2'd2) |-> (msg_q.data2 == 7'd0))
    else $error("two-byte message with nonzero second data byte");

  a_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_q.valid |-> (msg_q.length != 2'd0 && msg_q.status[7]))
    else $error("emitted message with zero length or data status");

  a_idle_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE) |-> (state_q.running_status == 8'h00))
    else $error("idle phase with running status held");

  a_active_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != PH_IDLE) |-> state_q.running_status[7])
    else $error("active phase without a status byte");

endmodule
